@@ hdl/dsv_pkg.sv @@
// shared types, constants and table functions for the date string validator
// no dependencies
package dsv_pkg;

   localparam logic [19:0] ACC_MAX        = 20'hFFFFF;
   localparam logic [15:0] CNT_MAX        = 16'hFFFF;
   localparam logic [19:0] MAX_YEAR_RESET = 20'd9999;

   // floor(y / 100) == (y * DIV100_MUL) >> DIV100_SHIFT for every 20-bit y
   localparam logic [20:0] DIV100_MUL   = 21'd1342178;
   localparam int          DIV100_SHIFT = 27;

   localparam logic [7:0] CH_SPACE = 8'd32;
   localparam logic [7:0] CH_TAB   = 8'd9;
   localparam logic [7:0] CH_CR    = 8'd13;
   localparam logic [7:0] CH_PLUS  = 8'd43;
   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_ZERO  = 8'd48;
   localparam logic [7:0] CH_NINE  = 8'd57;

   localparam logic [28:0] DAYS_YEAR   = 29'd365;
   localparam logic [28:0] SERIAL_BIAS = 29'd306;

   typedef enum logic [9:0] {
      PH_Y_WS   = 10'b0000000001,
      PH_Y_SIGN = 10'b0000000010,
      PH_Y_DIG  = 10'b0000000100,
      PH_M_WS   = 10'b0000001000,
      PH_M_SIGN = 10'b0000010000,
      PH_M_DIG  = 10'b0000100000,
      PH_D_WS   = 10'b0001000000,
      PH_D_SIGN = 10'b0010000000,
      PH_D_DIG  = 10'b0100000000,
      PH_DONE   = 10'b1000000000
   } phase_type;

   // (153 * mm - 457) / 5 with january and february as months 13 and 14
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] r;
      case (m)
         4'd1:    r = 9'd306;
         4'd2:    r = 9'd337;
         4'd3:    r = 9'd0;
         4'd4:    r = 9'd31;
         4'd5:    r = 9'd61;
         4'd6:    r = 9'd92;
         4'd7:    r = 9'd122;
         4'd8:    r = 9'd153;
         4'd9:    r = 9'd184;
         4'd10:   r = 9'd214;
         4'd11:   r = 9'd245;
         4'd12:   r = 9'd275;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
      logic [4:0] r;
      case (m)
         4'd2:                       r = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:    r = 5'd30;
         default:                    r = 5'd31;
      endcase
      return r;
   endfunction

endpackage

@@ hdl/date_string_validate_day_serial_top.sv @@
// date string parser and validator with days-from-civil serial, one byte per beat
// depends on dsv_pkg
// result path: the last byte's result passes stage 1, stage 2, stage 3 and the output register before rsp_valid rises
// throughput: one byte per cycle; three result stages and the output register hold one
// beat each, and the input stalls only while all four are full and rsp_ready is low
// reset: synchronous, clears the parser, all stage valid bits and sets max_year to 9999
module date_string_validate_day_serial_top
   import dsv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_ch,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_valid_res,
   output logic [19:0] rsp_year,
   output logic [3:0]  rsp_month,
   output logic [4:0]  rsp_day,
   output logic [28:0] rsp_day_serial,
   output logic [15:0] rsp_consumed_bytes,
   input  logic        csr_write_enable,
   input  logic [19:0] csr_write_data
);

   logic [19:0] max_year_ff;

   // parser state
   phase_type   phase_ff, phase_in;
   logic [19:0] acc_ff, acc_in;
   logic        ovf_ff, ovf_in;
   logic        bad_ff, bad_in;
   logic [19:0] hyear_ff, hyear_in;
   logic [3:0]  hmonth_ff, hmonth_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [15:0] endp_ff, endp_in;

   // stage valid bits and handshake chain
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic rdy1, rdy2, rdy3, rdy_out;
   logic req_accept, req_accept_last;

   // stage 1: parsed fields
   logic        s1_ok_ff, s1_ok_in;
   logic [19:0] s1_year_ff;
   logic [3:0]  s1_month_ff;
   logic [19:0] s1_day_ff;
   logic [15:0] s1_end_ff, s1_end_in;

   // stage 2: range checks and products
   logic        s2_ok_ff, s2_ok_in;
   logic [19:0] s2_year_ff;
   logic [3:0]  s2_month_ff;
   logic [4:0]  s2_day_ff;
   logic [15:0] s2_end_ff;
   logic        s2_early_ff;
   logic [13:0] s2_q100_ff, s2_q100_in;
   logic [28:0] s2_p365_ff, s2_p365_in;
   logic [8:0]  s2_moff_ff;
   logic [40:0] s2_prod;

   // stage 3: leap check and partial serial
   logic        s3_ok_ff, s3_ok_in;
   logic [19:0] s3_year_ff;
   logic [3:0]  s3_month_ff;
   logic [4:0]  s3_day_ff;
   logic [15:0] s3_end_ff;
   logic [28:0] s3_part_ff, s3_part_in;
   logic [17:0] s3_yq4_ff, s3_yq4_in;
   logic [13:0] s3_cq_ff, s3_cq_in;
   logic [19:0] s3_r100;
   logic        s3_leap;
   logic [19:0] s3_yy;

   // output register
   logic        rsp_ok_ff;
   logic [19:0] rsp_year_ff;
   logic [3:0]  rsp_month_ff;
   logic [4:0]  rsp_day_ff;
   logic [28:0] rsp_serial_ff, rsp_serial_in;
   logic [15:0] rsp_end_ff;

   // byte classification
   logic        ch_digit, ch_space, ch_plus, ch_minus;
   logic [3:0]  ch_val;
   logic [23:0] acc_sum;
   phase_type   sign_ph, dig_ph;

   assign rdy_out         = !rsp_valid_ff || rsp_ready;
   assign rdy3            = !s3_valid_ff || rdy_out;
   assign rdy2            = !s2_valid_ff || rdy3;
   assign rdy1            = !s1_valid_ff || rdy2;
   assign req_ready       = rdy1;
   assign req_accept      = req_valid && rdy1;
   assign req_accept_last = req_accept && req_last;

   assign ch_digit = (req_ch >= CH_ZERO) && (req_ch <= CH_NINE);
   assign ch_space = (req_ch == CH_SPACE) || ((req_ch >= CH_TAB) && (req_ch <= CH_CR));
   assign ch_plus  = (req_ch == CH_PLUS);
   assign ch_minus = (req_ch == CH_MINUS);
   assign ch_val   = 4'(req_ch - CH_ZERO);
   assign acc_sum  = ({4'b0, acc_ff} << 3) + ({4'b0, acc_ff} << 1) + {20'b0, ch_val};

   always_comb begin
      unique case (phase_ff)
         PH_M_WS, PH_M_SIGN: begin
            sign_ph = PH_M_SIGN;
            dig_ph  = PH_M_DIG;
         end
         PH_D_WS, PH_D_SIGN: begin
            sign_ph = PH_D_SIGN;
            dig_ph  = PH_D_DIG;
         end
         default: begin
            sign_ph = PH_Y_SIGN;
            dig_ph  = PH_Y_DIG;
         end
      endcase
   end

   always_comb begin
      phase_in  = phase_ff;
      acc_in    = acc_ff;
      ovf_in    = ovf_ff;
      bad_in    = bad_ff;
      hyear_in  = hyear_ff;
      hmonth_in = hmonth_ff;
      endp_in   = endp_ff;
      cnt_in    = (cnt_ff == CNT_MAX) ? cnt_ff : cnt_ff + 16'd1;
      unique case (phase_ff)
         PH_Y_WS, PH_M_WS, PH_D_WS: begin
            if (ch_plus) begin
               phase_in = sign_ph;
            end else if (ch_digit) begin
               acc_in   = {16'b0, ch_val};
               phase_in = dig_ph;
            end else if (!ch_space) begin
               bad_in   = 1'b1;
               phase_in = PH_DONE;
            end
         end
         PH_Y_SIGN, PH_M_SIGN, PH_D_SIGN: begin
            if (ch_digit) begin
               acc_in   = {16'b0, ch_val};
               phase_in = dig_ph;
            end else begin
               bad_in   = 1'b1;
               phase_in = PH_DONE;
            end
         end
         PH_Y_DIG, PH_M_DIG, PH_D_DIG: begin
            if (ch_digit) begin
               if (acc_sum[23:20] != 4'd0) begin
                  ovf_in = 1'b1;
                  acc_in = ACC_MAX;
               end else begin
                  acc_in = acc_sum[19:0];
               end
            end else if (phase_ff == PH_D_DIG) begin
               endp_in  = cnt_ff;
               phase_in = PH_DONE;
            end else if (ch_minus && phase_ff == PH_Y_DIG) begin
               hyear_in = acc_ff;
               acc_in   = 20'd0;
               phase_in = PH_M_WS;
            end else if (ch_minus && acc_ff >= 20'd1 && acc_ff <= 20'd12) begin
               hmonth_in = acc_ff[3:0];
               acc_in    = 20'd0;
               phase_in  = PH_D_WS;
            end else begin
               bad_in   = 1'b1;
               phase_in = PH_DONE;
            end
         end
         default: begin
         end
      endcase
   end

   assign s1_end_in = (phase_in == PH_D_DIG) ? cnt_in : endp_in;
   assign s1_ok_in  = ((phase_in == PH_D_DIG) || (phase_in == PH_DONE)) && !bad_in && !ovf_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_year_ff <= MAX_YEAR_RESET;
      end else if (csr_write_enable) begin
         max_year_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || req_accept_last) begin
         phase_ff  <= PH_Y_WS;
         acc_ff    <= 20'd0;
         ovf_ff    <= 1'b0;
         bad_ff    <= 1'b0;
         hyear_ff  <= 20'd0;
         hmonth_ff <= 4'd0;
         cnt_ff    <= 16'd0;
         endp_ff   <= 16'd0;
      end else if (req_accept) begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         ovf_ff    <= ovf_in;
         bad_ff    <= bad_in;
         hyear_ff  <= hyear_in;
         hmonth_ff <= hmonth_in;
         cnt_ff    <= cnt_in;
         endp_ff   <= endp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) begin
            s1_valid_ff <= req_accept_last;
         end
         if (rdy2) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (rdy3) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (rdy_out) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   // stage 2 datapath
   assign s2_prod    = 41'(s1_year_ff) * 41'(DIV100_MUL);
   assign s2_q100_in = s2_prod[40:DIV100_SHIFT];
   assign s2_p365_in = 29'(s1_year_ff) * DAYS_YEAR;
   assign s2_ok_in   = s1_ok_ff && (s1_year_ff >= 20'd2) && (s1_year_ff <= max_year_ff)
                       && (s1_month_ff >= 4'd1) && (s1_month_ff <= 4'd12)
                       && (s1_day_ff >= 20'd1) && (s1_day_ff <= 20'd31);

   // stage 3 datapath
   assign s3_r100    = s2_year_ff - 20'((s2_q100_ff << 6) + (s2_q100_ff << 5) + (s2_q100_ff << 2));
   assign s3_leap    = (s2_year_ff[1:0] == 2'd0)
                       && ((s3_r100 != 20'd0) || (s2_q100_ff[1:0] == 2'd0));
   assign s3_ok_in   = s2_ok_ff && (s2_day_ff <= month_days(s2_month_ff, s3_leap));
   assign s3_yy      = s2_year_ff - {19'b0, s2_early_ff};
   assign s3_yq4_in  = s3_yy[19:2];
   assign s3_cq_in   = (s2_early_ff && s3_r100 == 20'd0) ? s2_q100_ff - 14'd1 : s2_q100_ff;
   assign s3_part_in = s2_p365_ff - (s2_early_ff ? DAYS_YEAR : 29'd0) + 29'(s2_moff_ff)
                       + 29'(s2_day_ff) - SERIAL_BIAS;

   // output datapath
   assign rsp_serial_in = s3_part_ff + 29'(s3_yq4_ff) - 29'(s3_cq_ff) + 29'(s3_cq_ff[13:2]);

   always_ff @(posedge clock) begin
      if (req_accept_last) begin
         s1_ok_ff    <= s1_ok_in;
         s1_year_ff  <= hyear_in;
         s1_month_ff <= hmonth_in;
         s1_day_ff   <= acc_in;
         s1_end_ff   <= s1_end_in;
      end
      if (s1_valid_ff && rdy2) begin
         s2_ok_ff    <= s2_ok_in;
         s2_year_ff  <= s1_year_ff;
         s2_month_ff <= s1_month_ff;
         s2_day_ff   <= s1_day_ff[4:0];
         s2_end_ff   <= s1_end_ff;
         s2_early_ff <= (s1_month_ff <= 4'd2);
         s2_q100_ff  <= s2_q100_in;
         s2_p365_ff  <= s2_p365_in;
         s2_moff_ff  <= month_offset(s1_month_ff);
      end
      if (s2_valid_ff && rdy3) begin
         s3_ok_ff    <= s3_ok_in;
         s3_year_ff  <= s2_year_ff;
         s3_month_ff <= s2_month_ff;
         s3_day_ff   <= s2_day_ff;
         s3_end_ff   <= s2_end_ff;
         s3_part_ff  <= s3_part_in;
         s3_yq4_ff   <= s3_yq4_in;
         s3_cq_ff    <= s3_cq_in;
      end
      if (s3_valid_ff && rdy_out) begin
         rsp_ok_ff     <= s3_ok_ff;
         rsp_year_ff   <= s3_ok_ff ? s3_year_ff : 20'd0;
         rsp_month_ff  <= s3_ok_ff ? s3_month_ff : 4'd0;
         rsp_day_ff    <= s3_ok_ff ? s3_day_ff : 5'd0;
         rsp_serial_ff <= s3_ok_ff ? rsp_serial_in : 29'd0;
         rsp_end_ff    <= s3_ok_ff ? s3_end_ff : 16'd0;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_valid_res      = rsp_ok_ff;
   assign rsp_year           = rsp_year_ff;
   assign rsp_month          = rsp_month_ff;
   assign rsp_day            = rsp_day_ff;
   assign rsp_day_serial     = rsp_serial_ff;
   assign rsp_consumed_bytes = rsp_end_ff;

`ifndef SYNTHESIS
   a_last_enters_pipe: assert property (@(posedge clock) disable iff (reset)
      req_accept_last |=> s1_valid_ff)
      else $error("last beat did not enter the result pipeline");

   a_parser_restarts: assert property (@(posedge clock) disable iff (reset)
      req_accept_last |=> (phase_ff == PH_Y_WS) && (cnt_ff == 16'd0))
      else $error("parser did not restart after last beat");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_valid_res) |-> (rsp_year == 20'd0) && (rsp_month == 4'd0)
         && (rsp_day == 5'd0) && (rsp_day_serial == 29'd0) && (rsp_consumed_bytes == 16'd0))
      else $error("invalid result carries nonzero fields");

   a_valid_ranges: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_valid_res) |-> (rsp_month >= 4'd1) && (rsp_month <= 4'd12)
         && (rsp_day >= 5'd1) && (rsp_year >= 20'd2))
      else $error("valid result out of range");
`endif

endmodule
